// ===== rtl/core/cphash_pkg.sv =====
`default_nettype none

package cphash_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 8;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_DUP  = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_HIT  = 3'd3;
	localparam logic [2:0] ST_MISS = 3'd4;

	// mix hash multipliers
	localparam logic [KEY_W-1:0] HASH_MUL1 = 32'h7feb352d;
	localparam logic [KEY_W-1:0] HASH_MUL2 = 32'h846ca68b;

	localparam logic [7:0] FORCED_ALPHA = 8'hFF;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] index;
	} slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/color_to_palette_index_hash_top.sv =====
`default_nettype none
// Sequence: an insert/lookup word taken in S_IDLE passes S_HASH2, S_HASH3, S_MOD (only when
//   the table size is not a power of two) and S_PROBE, once per probe; the result is registered.
// Flow: one item at a time; one probe per cycle from the single slot memory while the result
//   register is not stalled; a clear item sweeps the used marks, then posts its result.
// Reset: arst_n clears control state, alpha_present returns to 1, then a sweep of every slot
//   empties the used marks while s_axis_tready is held low.

module color_to_palette_index_hash_top #(
	parameter int TABLE_SLOTS = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // color_word [31:0], entry_index [39:32], zero pad
	input  wire logic [1:0]  s_axis_tuser,  // command [1:0]
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // found_index [7:0]
	output logic [2:0]       m_axis_tuser,  // status [2:0]
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);
	localparam logic [AW:0]   SLOTS_W   = (AW + 1)'(TABLE_SLOTS);
	// power-of-two tables take the slot straight from the low hash bits
	localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

	// sequencer states
	localparam logic [2:0] S_SWEEP = 3'd0;  // clearing used marks
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH2 = 3'd2;  // second multiply
	localparam logic [2:0] S_HASH3 = 3'd3;  // final xor-shift, slot select
	localparam logic [2:0] S_MOD   = 3'd4;  // remainder by table size, 4 bits a cycle
	localparam logic [2:0] S_PROBE = 3'd5;  // one slot compared per cycle while the result is not stalled
	localparam logic [2:0] S_POST  = 3'd6;  // fixed result for clear / unused command

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] slot_q, slot_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic [2:0]    step_q, step_d;
	logic          rpt_q, rpt_d;
	logic          alpha_q;

	// item payload
	logic [1:0]  cmd_q;
	logic [31:0] key_q;
	logic [7:0]  idx_q;
	logic [31:0] mix_s1, mix_s2;
	logic [31:0] mod_h_q;
	logic [AW-1:0] rem_q, rem_nx;

	// slot memory
	cphash_pkg::slot_t mem [TABLE_SLOTS];
	cphash_pkg::slot_t rd_q;
	cphash_pkg::slot_t mem_wd;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;

	// result register
	logic       m_valid_q;
	logic [2:0] m_status_q;
	logic [7:0] m_index_q;
	logic       out_free, out_load;
	logic       fin;
	logic [2:0] fin_status;
	logic [7:0] fin_index;

	logic        in_acc;
	logic [31:0] in_key, k1, k2, hash_v;
	logic [31:0] prod1, prod2;
	logic        match, last_probe;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign out_load      = fin && out_free;

	// register port: alpha_present at address 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, alpha_q} : 32'd0;

	// key as hashed: lookups force opaque alpha when alpha is off
	always_comb begin
		in_key = s_axis_tdata[31:0];
		if (s_axis_tuser == cphash_pkg::CMD_LOOKUP && !alpha_q) begin
			in_key[7:0] = cphash_pkg::FORCED_ALPHA;
		end
	end

	// only the low 32 product bits feed the mix
	assign k1     = in_key ^ (in_key >> 16);
	assign prod1  = k1 * cphash_pkg::HASH_MUL1;
	assign k2     = mix_s1 ^ (mix_s1 >> 15);
	assign prod2  = k2 * cphash_pkg::HASH_MUL2;
	assign hash_v = mix_s2 ^ (mix_s2 >> 16);

	// restoring remainder, four hash bits per cycle
	always_comb begin
		logic [AW:0] tmp;
		rem_nx = rem_q;
		for (int i = 0; i < 4; i++) begin
			tmp = {rem_nx, mod_h_q[31-i]};
			if (tmp >= SLOTS_W) begin
				tmp = tmp - SLOTS_W;
			end
			rem_nx = tmp[AW-1:0];
		end
	end

	assign match      = rd_q.used && (rd_q.key == key_q);
	assign last_probe = (cnt_q == LAST_SLOT);

	always_comb begin
		state_d    = state_q;
		slot_d     = slot_q;
		cnt_d      = cnt_q;
		step_d     = step_q;
		rpt_d      = rpt_q;
		mem_we     = 1'b0;
		mem_wa     = slot_q;
		mem_wd     = '{used: 1'b1, key: key_q, index: idx_q};
		fin        = 1'b0;
		fin_status = cphash_pkg::ST_DONE;
		fin_index  = 8'd0;
		case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = '{used: 1'b0, key: 32'd0, index: 8'd0};
				if (cnt_q == LAST_SLOT) begin
					cnt_d   = '0;
					state_d = rpt_q ? S_POST : S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					case (s_axis_tuser)
						cphash_pkg::CMD_CLEAR: begin
							state_d = S_SWEEP;
							cnt_d   = '0;
							rpt_d   = 1'b1;
						end
						cphash_pkg::CMD_INSERT,
						cphash_pkg::CMD_LOOKUP: state_d = S_HASH2;
						default: state_d = S_POST;
					endcase
				end
			end
			S_HASH2: state_d = S_HASH3;
			S_HASH3: begin
				cnt_d = '0;
				if (IS_POW2) begin
					slot_d  = hash_v[AW-1:0];
					state_d = S_PROBE;
				end else begin
					step_d  = '0;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				step_d = step_q + 1'b1;
				if (step_q == 3'd7) begin
					slot_d  = rem_nx;
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (!rd_q.used) begin
					fin = 1'b1;
					if (cmd_q == cphash_pkg::CMD_INSERT) begin
						fin_status = cphash_pkg::ST_DONE;
						mem_we     = out_free;
					end else begin
						fin_status = cphash_pkg::ST_MISS;
					end
				end else if (match) begin
					fin = 1'b1;
					if (cmd_q == cphash_pkg::CMD_INSERT) begin
						fin_status = cphash_pkg::ST_DUP;
					end else begin
						fin_status = cphash_pkg::ST_HIT;
						fin_index  = rd_q.index;
					end
				end else if (last_probe) begin
					fin        = 1'b1;
					fin_status = (cmd_q == cphash_pkg::CMD_INSERT) ?
						cphash_pkg::ST_FULL : cphash_pkg::ST_MISS;
				end else begin
					slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
				// stalled result: hold slot, re-read gives the same word
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			S_POST: begin
				fin = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			slot_q    <= '0;
			cnt_q     <= '0;
			step_q    <= '0;
			rpt_q     <= 1'b0;
			alpha_q   <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			rpt_q   <= rpt_d;
			if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
				alpha_q <= pwdata[0];
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload and hash pipeline
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= s_axis_tuser;
			key_q  <= in_key;
			idx_q  <= s_axis_tdata[39:32];
			mix_s1 <= prod1;
		end
		mix_s2 <= prod2;
		if (state_q == S_HASH3) begin
			mod_h_q <= hash_v;
			rem_q   <= '0;
		end else if (state_q == S_MOD) begin
			mod_h_q <= mod_h_q << 4;
			rem_q   <= rem_nx;
		end
		if (out_load) begin
			m_status_q <= fin_status;
			m_index_q  <= fin_index;
		end
	end

	// slot memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[slot_d];
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_index_q;
	assign m_axis_tuser  = m_status_q;

	// a taken insert or lookup word always starts the hash
	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (s_axis_tuser == cphash_pkg::CMD_INSERT ||
			s_axis_tuser == cphash_pkg::CMD_LOOKUP)) |=> state_q == S_HASH2)
		else $error("insert/lookup did not enter hash stage");

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_axis_tready))
		else $error("result overwrote a pending word");

	// probe writes only fill an empty slot for an insert
	a_probe_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == S_PROBE) |->
			(cmd_q == cphash_pkg::CMD_INSERT && !rd_q.used && mem_wa == slot_q))
		else $error("unexpected slot write during probe");

	// no memory write outside sweep and probe
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SWEEP || state_q == S_PROBE))
		else $error("slot write in wrong state");

	// a hit carries the index just read
	a_hit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && fin_status == cphash_pkg::ST_HIT) |=> m_axis_tdata == $past(rd_q.index))
		else $error("hit index mismatch");

endmodule

`default_nettype wire

// ===== tb/sv/color_to_palette_index_hash_top_tb.sv =====
module color_to_palette_index_hash_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 512;
	// command 3 has no meaning; the block must answer it as done and leave the table alone
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// alpha_present is register 0
	localparam logic [2:0] REG_ALPHA = 3'd0;
	// odd step, so base + i * step never repeats within the table fill
	localparam logic [cphash_pkg::KEY_W-1:0] KEY_STRIDE = 32'h9E3779B9;
	localparam int POOL_CAP = 300;
	localparam int SETTLE_CYCLES = 8;

	// ------------------------------------------------------------------
	// clock, reset and every block input, known from time zero
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // color_word [31:0], entry_index [39:32], zero pad
	logic [1:0]  s_axis_tuser = '0;   // command [1:0]
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [7:0]  m_axis_tdata;        // found_index [7:0]
	wire  [2:0]  m_axis_tuser;        // status [2:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	always #2 clk = ~clk;

	color_to_palette_index_hash_top #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ------------------------------------------------------------------
	// scoreboard: own copy of the hash table, one answer queued per word in
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [2:0]                   status;
		logic [cphash_pkg::IDX_W-1:0] index;
	} palette_answer_t;

	class palette_board;
		logic [cphash_pkg::KEY_W-1:0] keys [SLOTS];
		logic [cphash_pkg::IDX_W-1:0] idxs [SLOTS];
		bit               used [SLOTS];
		bit               alpha_on;
		palette_answer_t  answers_due[$];
		int               words_in;
		int               results;
		int               mismatches;
		int               by_status [8];

		function new();
			alpha_on = 1'b1;
			words_in = 0;
			results = 0;
			mismatches = 0;
			foreach (used[i]) used[i] = 1'b0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		// xor-shift / multiply mix, reduced to a slot number
		static function int home_of(logic [cphash_pkg::KEY_W-1:0] k);
			k ^= k >> 16;
			k = k * cphash_pkg::HASH_MUL1;
			k ^= k >> 15;
			k = k * cphash_pkg::HASH_MUL2;
			k ^= k >> 16;
			return int'(k % SLOTS);
		endfunction

		function logic [2:0] insert_key(logic [cphash_pkg::KEY_W-1:0] k,
						logic [cphash_pkg::IDX_W-1:0] ix);
			int s;
			s = home_of(k);
			for (int n = 0; n < SLOTS; n++) begin
				if (!used[s]) begin
					used[s] = 1'b1;
					keys[s] = k;
					idxs[s] = ix;
					return cphash_pkg::ST_DONE;
				end
				if (keys[s] == k)
					return cphash_pkg::ST_DUP;
				s = (s + 1) % SLOTS;
			end
			return cphash_pkg::ST_FULL;
		endfunction

		function palette_answer_t lookup_key(logic [cphash_pkg::KEY_W-1:0] k);
			palette_answer_t ans;
			int s;
			ans = '{status: cphash_pkg::ST_MISS, index: '0};
			s = home_of(k);
			for (int n = 0; n < SLOTS; n++) begin
				if (!used[s])
					return ans;
				if (keys[s] == k) begin
					ans.status = cphash_pkg::ST_HIT;
					ans.index = idxs[s];
					return ans;
				end
				s = (s + 1) % SLOTS;
			end
			return ans;
		endfunction

		function void set_alpha(bit v);
			alpha_on = v;
		endfunction

		function void note_word(logic [1:0] cmd, logic [cphash_pkg::KEY_W-1:0] color,
					logic [cphash_pkg::IDX_W-1:0] ix);
			palette_answer_t ans;
			ans = '{status: cphash_pkg::ST_DONE, index: '0};
			words_in++;
			case (cmd)
				cphash_pkg::CMD_CLEAR: begin
					foreach (used[i]) used[i] = 1'b0;
				end
				cphash_pkg::CMD_INSERT: begin
					ans.status = insert_key(color, ix);
				end
				cphash_pkg::CMD_LOOKUP: begin
					if (!alpha_on)
						color[7:0] = cphash_pkg::FORCED_ALPHA;
					ans = lookup_key(color);
				end
				default: ;
			endcase
			answers_due.push_back(ans);
		endfunction

		function void check_result(logic [2:0] status, logic [cphash_pkg::IDX_W-1:0] index);
			palette_answer_t want;
			results++;
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: status %0d index 0x%02h",
						results, status, index);
				return;
			end
			want = answers_due.pop_front();
			by_status[want.status]++;
			if (status !== want.status || index !== want.index) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch on result %0d: expected status %0d index 0x%02h,",
						" got status %0d index 0x%02h"},
						results, want.status, want.index, status, index);
			end
		endfunction
	endclass

	palette_board sb;

	// ------------------------------------------------------------------
	// handshake pressure knobs, changed only between phases
	// ------------------------------------------------------------------
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	bit alpha_now = 1'b1;          // what the register holds, as far as stimulus knows
	logic [cphash_pkg::KEY_W-1:0] palette_pool[$];  // keys inserted since the last clear

	function automatic bit pct_hit(int p);
		return $urandom_range(99) < p;
	endfunction

	// result side: take a word whenever valid meets ready, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
		m_axis_tready <= !pct_hit(recv_stall_pct);
	end

	// one input word; valid is left high afterwards so back-to-back words need no bubble
	task automatic send_word(logic [1:0] cmd, logic [cphash_pkg::KEY_W-1:0] color,
				 logic [cphash_pkg::IDX_W-1:0] ix);
		while (pct_hit(sender_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {8'h00, ix, color};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_word(cmd, color, ix);
	endtask

	// drop valid, wait for every answer, then a short pad so the block is truly idle
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, then access until pready
	task automatic write_alpha(bit v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ALPHA;
		pwdata  <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		alpha_now = v;
		sb.set_alpha(v);
	endtask

	// random key whose home slot is the given one, distinct from two others
	function automatic logic [cphash_pkg::KEY_W-1:0] key_homed_at(int slot,
			logic [cphash_pkg::KEY_W-1:0] a, logic [cphash_pkg::KEY_W-1:0] b);
		logic [cphash_pkg::KEY_W-1:0] k;
		do k = $urandom; while (palette_board::home_of(k) != slot || k == a || k == b);
		return k;
	endfunction

	// short hand-picked sequence: field extremes, every command, duplicate, wrap, alpha forcing
	task automatic directed_words();
		logic [cphash_pkg::KEY_W-1:0] k1, k2, k3;
		k1 = key_homed_at(SLOTS - 1, 32'h0, 32'h0);
		k2 = key_homed_at(SLOTS - 1, k1, k1);
		k3 = key_homed_at(SLOTS - 1, k1, k2);
		send_word(cphash_pkg::CMD_LOOKUP, 32'h00000000, 8'h00);  // empty table: miss
		send_word(cphash_pkg::CMD_INSERT, 32'h00000000, 8'h00);
		send_word(cphash_pkg::CMD_INSERT, 32'hFFFFFFFF, 8'hFF);
		send_word(cphash_pkg::CMD_LOOKUP, 32'h00000000, 8'hFF);
		send_word(cphash_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 8'h00);
		send_word(cphash_pkg::CMD_INSERT, 32'hFFFFFFFF, 8'h12);  // duplicate, old index stays
		send_word(cphash_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 8'h00);
		send_word(CMD_UNUSED, 32'h5A5AA5A5, 8'hC3);  // ignored
		send_word(cphash_pkg::CMD_INSERT, 32'h11223344, 8'hA5);
		send_word(cphash_pkg::CMD_LOOKUP, 32'h112233FF, 8'h00);  // alpha honoured: miss
		// two keys on the last slot: the second wraps round to slot 0
		send_word(cphash_pkg::CMD_INSERT, k1, 8'h01);
		send_word(cphash_pkg::CMD_INSERT, k2, 8'h02);
		send_word(cphash_pkg::CMD_LOOKUP, k2, 8'h00);
		send_word(cphash_pkg::CMD_LOOKUP, k3, 8'h00);
		settle();
		write_alpha(1'b0);
		send_word(cphash_pkg::CMD_INSERT, 32'h112233FF, 8'h5A);
		send_word(cphash_pkg::CMD_LOOKUP, 32'h11223300, 8'h00);  // alpha forced opaque: hit
		send_word(cphash_pkg::CMD_LOOKUP, 32'h11223344, 8'h00);
		send_word(cphash_pkg::CMD_INSERT, 32'hAABBCC00, 8'h03);  // inserts keep alpha as given
		send_word(cphash_pkg::CMD_LOOKUP, 32'hAABBCC00, 8'h00);
		send_word(cphash_pkg::CMD_CLEAR, 32'h00000000, 8'h00);
		send_word(cphash_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 8'h00);
		send_word(cphash_pkg::CMD_INSERT, 32'hFFFFFFFF, 8'h80);
		send_word(cphash_pkg::CMD_LOOKUP, 32'hFFFFFFFF, 8'h00);
		settle();
	endtask

	// fill every slot, then full-table insert, duplicate, hits and a full-length miss walk
	task automatic fill_table();
		logic [cphash_pkg::KEY_W-1:0] base;
		base = $urandom;
		send_word(cphash_pkg::CMD_CLEAR, base, 8'h00);
		for (int i = 0; i < SLOTS; i++)
			send_word(cphash_pkg::CMD_INSERT, base + i * KEY_STRIDE,
				8'($urandom_range(255)));
		send_word(cphash_pkg::CMD_INSERT, base + SLOTS * KEY_STRIDE, 8'($urandom_range(255)));
		send_word(cphash_pkg::CMD_INSERT, base, 8'($urandom_range(255)));
		repeat (4)
			send_word(cphash_pkg::CMD_LOOKUP,
				base + $urandom_range(SLOTS - 1) * KEY_STRIDE, 8'h00);
		send_word(cphash_pkg::CMD_LOOKUP, base + (SLOTS + 1) * KEY_STRIDE, 8'h00);
		send_word(cphash_pkg::CMD_CLEAR, base, 8'h00);
		palette_pool.delete();
	endtask

	// mostly inserts and lookups of known keys, some random misses, rare clears and junk
	task automatic random_word();
		int                           pick;
		logic [cphash_pkg::KEY_W-1:0] k;
		logic [cphash_pkg::IDX_W-1:0] ix;
		pick = $urandom_range(99);
		k = $urandom;
		ix = 8'($urandom_range(255));
		if (pick < 2 || (pick < 40 && palette_pool.size() >= POOL_CAP)) begin
			send_word(cphash_pkg::CMD_CLEAR, k, ix);
			palette_pool.delete();
		end else if (pick < 3) begin
			send_word(CMD_UNUSED, k, ix);
		end else if (pick < 40) begin
			if (palette_pool.size() != 0 && pct_hit(30)) begin
				k = palette_pool[$urandom_range(palette_pool.size() - 1)];
			end else begin
				if (!alpha_now && pct_hit(60))
					k[7:0] = cphash_pkg::FORCED_ALPHA;
				palette_pool.push_back(k);
			end
			send_word(cphash_pkg::CMD_INSERT, k, ix);
		end else if (pick < 85 && palette_pool.size() != 0) begin
			k = palette_pool[$urandom_range(palette_pool.size() - 1)];
			if (!alpha_now && pct_hit(50))
				k[7:0] = 8'($urandom_range(255));
			send_word(cphash_pkg::CMD_LOOKUP, k, ix);
		end else begin
			send_word(cphash_pkg::CMD_LOOKUP, k, ix);
		end
	endtask

	task automatic run_phase(int words, int idle_pct, int stall_pct, bit alpha);
		settle();
		write_alpha(alpha);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (words) random_word();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		directed_words();

		settle();
		write_alpha(1'b1);
		fill_table();

		// idle patterns: none, sender gaps, receiver stalls, both
		run_phase(320, 0, 0, 1'b0);
		run_phase(320, 71, 0, 1'b1);
		run_phase(320, 0, 71, 1'b0);
		run_phase(320, 32, 32, 1'b1);
		settle();
		repeat (32) @(posedge clk);

		$display({"covered %0d words in, %0d results: %0d done, %0d duplicates,",
			" %0d full, %0d hits, %0d misses"},
			sb.words_in, sb.results, sb.by_status[cphash_pkg::ST_DONE],
			sb.by_status[cphash_pkg::ST_DUP], sb.by_status[cphash_pkg::ST_FULL],
			sb.by_status[cphash_pkg::ST_HIT], sb.by_status[cphash_pkg::ST_MISS]);
		$display("alpha on and off, one full-table fill, four idle patterns; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.answers_due.size() == 0)
			$display("** color_to_palette_index_hash_top: PASSED **");
		else
			$display("** color_to_palette_index_hash_top: FAILED **");
		$finish;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		#8_000_000;
		$display("** color_to_palette_index_hash_top: FAILED **");
		$finish;
	end

endmodule
